### sv/text_to_integer_parser_defines.svh
// assertion macros shared by the parser modules
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef TEXT_TO_INTEGER_PARSER_DEFINES_SVH
`define TEXT_TO_INTEGER_PARSER_DEFINES_SVH

// condition implies consequence in the same cycle
`define TTIP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the cycle after
`define TTIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/ttip_pkg.sv
// shared types and character constants for the text to integer parser
// no dependencies
package ttip_pkg;

	localparam int CH_W    = 8;
	localparam int BASE_W  = 6;
	localparam int VALUE_W = 64;

	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_UA    = 8'h41;
	localparam logic [CH_W-1:0] CH_UX    = 8'h58;
	localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CH_W-1:0] CH_LA    = 8'h61;
	localparam logic [CH_W-1:0] CH_LX    = 8'h78;
	localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
	localparam logic [CH_W-1:0] SYM_UPPER_OFS = CH_UA - 8'd10;
	localparam logic [CH_W-1:0] SYM_LOWER_OFS = CH_LA - 8'd10;

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

	localparam logic [VALUE_W-1:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] INT64_MIN = 64'h8000_0000_0000_0000;

	// classified character as it travels from front to back
	typedef struct packed {
		logic              last;
		logic              is_space;
		logic              is_minus;
		logic              is_plus;
		logic              is_zero;
		logic              is_x;
		logic              sym_ok;
		logic [BASE_W-1:0] sym;
	} ch_class_t;

	localparam int CLS_W = $bits(ch_class_t);

endpackage

### sv/text_to_integer_parser.sv
// top level of the streaming text to integer parser (64-bit signed, saturating)
// depends on ttip_pkg, ttip_front, ttip_fifo and ttip_back
//
//   channel   direction  payload                                      handshake
//   s_*       in         tdata: ch[7:0]; tlast: end of string          tvalid/tready
//   m_*       out        tdata: value, stop_offset, range_error,       tvalid/tready
//                        no_digits (low bit up), zero padded
//   base_*    in         number_base[5:0], reset value 10              write enable only
//
// one character per cycle while the queue has room; the back end's multiply-add of the
// accumulator is the loop that sets this rate, one queue slot per character in flight
// the last character is written to a queue slot, then its result to the result register
// arst_n clears the parse state, queue pointers and result valid; number_base goes to 10
// a stalled result holds the back end only on the next string's last character; other
// characters keep flowing into the queue and through the parse state
module text_to_integer_parser import ttip_pkg::*; #(
	parameter int MAX_STRING_LEN = 4096,
	parameter int QUEUE_DEPTH    = 4,
	localparam int POS_W   = $clog2(MAX_STRING_LEN + 1),
	localparam int TDATA_W = ((VALUE_W + POS_W + 2 + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write
	input  logic               base_we,
	input  logic [BASE_W-1:0]  base_wdata,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [CH_W-1:0]    s_tdata,   // ch
	input  logic               s_tlast,   // last character of the string
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata    // value, stop_offset, range_error, no_digits
);

	localparam int ENT_W = CLS_W + POS_W;

	logic [BASE_W-1:0]  base_q;

	// front to queue
	logic               f_push;
	ch_class_t          f_cls;
	logic [POS_W-1:0]   f_pos;
	logic               q_full;

	// queue to back
	logic               q_valid;
	logic               q_pop;
	logic [ENT_W-1:0]   q_rdata;
	ch_class_t          b_cls;
	logic [POS_W-1:0]   b_pos;

	// result fields
	logic [VALUE_W-1:0] value;
	logic [POS_W-1:0]   stop_offset;
	logic               range_error;
	logic               no_digits;

	// radix register, read by the back end when it decides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (base_we) begin
			base_q <= base_wdata;
		end
	end

	// classify and number each character on the transfer
	ttip_front #(
		.MAX_STRING_LEN (MAX_STRING_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_ch    (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.q_push   (f_push),
		.q_cls    (f_cls),
		.q_pos    (f_pos)
	);

	// decouples character intake from result backpressure
	ttip_fifo #(
		.W     (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_pos, f_cls}),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	assign b_cls = ch_class_t'(q_rdata[CLS_W-1:0]);
	assign b_pos = q_rdata[ENT_W-1:CLS_W];

	// parse state machine and result register
	ttip_back #(
		.MAX_STRING_LEN (MAX_STRING_LEN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_base (base_q),
		.q_valid     (q_valid),
		.q_cls       (b_cls),
		.q_pos       (b_pos),
		.q_pop       (q_pop),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.value       (value),
		.stop_offset (stop_offset),
		.range_error (range_error),
		.no_digits   (no_digits)
	);

	// pack fields from the low bit up, zero fill to whole bytes
	assign m_tdata = TDATA_W'({no_digits, range_error, stop_offset, value});

endmodule

### sv/ttip_front.sv
// front end: takes characters, classifies them and numbers them in the string
// depends on ttip_pkg
module ttip_front import ttip_pkg::*; #(
	parameter int MAX_STRING_LEN = 4096,
	localparam int POS_W = $clog2(MAX_STRING_LEN + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CH_W-1:0]  in_ch,
	input  logic             in_last,
	input  logic             q_full,
	output logic             q_push,
	output ch_class_t        q_cls,
	output logic [POS_W-1:0] q_pos
);

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_LEN);

	logic [POS_W-1:0] pos_q;

	function automatic ch_class_t classify(input logic [CH_W-1:0] c, input logic lst);
		ch_class_t r;
		logic [CH_W-1:0] d;
		r = '0;
		d = '1;
		r.last     = lst;
		r.is_space = (c == CH_SPACE);
		r.is_minus = (c == CH_MINUS);
		r.is_plus  = (c == CH_PLUS);
		r.is_zero  = (c == CH_ZERO);
		r.is_x     = (c == CH_LX) || (c == CH_UX);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = c - SYM_LOWER_OFS;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = c - SYM_UPPER_OFS;
		end
		r.sym_ok = (d != '1);
		r.sym    = d[BASE_W-1:0];
		return r;
	endfunction

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign q_cls    = classify(in_ch, in_last);
	assign q_pos    = pos_q;

	// position in the string, saturating, back to zero after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			if (in_last) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

### sv/ttip_fifo.sv
// short register queue between the front and back ends
// depends on the assertion macros in text_to_integer_parser_defines.svh
`include "text_to_integer_parser_defines.svh"
module ttip_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign valid = (count_q != '0);
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TTIP_ASSERT_NOW(a_no_overrun, push, !full || pop, "queue written while full")
	`TTIP_ASSERT_NOW(a_no_underrun, pop, valid, "queue read while empty")
	`TTIP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_FULL, "queue count beyond depth")

endmodule

### sv/ttip_back.sv
// back end: parse state machine, digit accumulation with overflow check, result register
// depends on ttip_pkg and the assertion macros in text_to_integer_parser_defines.svh
`include "text_to_integer_parser_defines.svh"
module ttip_back import ttip_pkg::*; #(
	parameter int MAX_STRING_LEN = 4096,
	localparam int POS_W = $clog2(MAX_STRING_LEN + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [BASE_W-1:0]  number_base,
	input  logic               q_valid,
	input  ch_class_t          q_cls,
	input  logic [POS_W-1:0]   q_pos,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [VALUE_W-1:0] value,
	output logic [POS_W-1:0]   stop_offset,
	output logic               range_error,
	output logic               no_digits
);

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_LEN);
	localparam int PROD_W = VALUE_W + BASE_W;

	localparam logic [2:0] PH_SPACE  = 3'd0;
	localparam logic [2:0] PH_SIGNED = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_DIGITS = 3'd3;
	localparam logic [2:0] PH_HEX    = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_SOME = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;

	logic [2:0]         phase_q, phase_n;
	logic               neg_q, neg_n;
	logic [VALUE_W-1:0] acc_q, acc_n;
	logic [1:0]         st_q, st_n;
	logic [BASE_W-1:0]  eb_q, eb_n;
	logic [POS_W-1:0]   stop_q, stop_n;

	logic               res_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]   stop_out_q;
	logic               range_q;
	logic               nodig_q;

	logic               take;
	logic               from_sign;
	logic [BASE_W-1:0]  eb_use;
	logic [1:0]         st_in;
	logic [VALUE_W-1:0] lim;
	logic [PROD_W-1:0]  prod;
	logic               d_ok;
	logic [POS_W-1:0]   end_pos;
	logic [VALUE_W-1:0] res_value;

	assign q_pop = q_valid && (!q_cls.last || !res_valid_q || res_ready);

	// one multiply-add per character; prod above the limit is the cutoff test
	assign lim     = neg_q ? INT64_MIN : INT64_MAX;
	assign prod    = PROD_W'(acc_q) * PROD_W'(eb_use) + PROD_W'(q_cls.sym);
	assign d_ok    = q_cls.sym_ok && (q_cls.sym < eb_use);
	assign end_pos = (q_pos == POS_MAX) ? q_pos : q_pos + 1'b1;

	always_comb begin
		phase_n   = phase_q;
		neg_n     = neg_q;
		acc_n     = acc_q;
		st_n      = st_q;
		eb_n      = eb_q;
		stop_n    = stop_q;
		take      = 1'b0;
		from_sign = 1'b0;
		eb_use    = eb_q;
		st_in     = st_q;
		case (phase_q)
			PH_SPACE: begin
				if (q_cls.is_minus) begin
					neg_n   = 1'b1;
					phase_n = PH_SIGNED;
				end else if (q_cls.is_plus) begin
					phase_n = PH_SIGNED;
				end else if (!q_cls.is_space) begin
					from_sign = 1'b1;
				end
			end
			PH_SIGNED: from_sign = 1'b1;
			PH_ZERO: begin
				if (q_cls.is_x) begin
					phase_n = PH_HEX;
				end else begin
					// the leading zero counts as a digit worth nothing
					eb_use = (number_base == BASE_AUTO) ? BASE_OCT : number_base;
					st_in  = ST_SOME;
					take   = 1'b1;
				end
			end
			PH_HEX: begin
				eb_use = BASE_HEX;
				take   = 1'b1;
			end
			PH_DIGITS: take = 1'b1;
			default: ;
		endcase
		if (from_sign) begin
			if ((number_base == BASE_AUTO || number_base == BASE_HEX) && q_cls.is_zero) begin
				phase_n = PH_ZERO;
			end else begin
				eb_use = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
				take   = 1'b1;
			end
		end
		if (take) begin
			eb_n    = eb_use;
			phase_n = PH_DIGITS;
			st_n    = st_in;
			if (!d_ok) begin
				stop_n  = q_pos;
				phase_n = PH_DONE;
			end else if (st_in == ST_OVER || prod > PROD_W'(lim)) begin
				st_n = ST_OVER;
			end else begin
				st_n  = ST_SOME;
				acc_n = prod[VALUE_W-1:0];
			end
		end
		// end of string acts as a terminator at the next position
		if (q_cls.last && phase_n != PH_DONE) begin
			if (phase_n == PH_ZERO) begin
				st_n   = ST_SOME;
				stop_n = end_pos;
			end else if (phase_n == PH_DIGITS) begin
				stop_n = end_pos;
			end
		end
	end

	always_comb begin
		if (st_n == ST_OVER) begin
			res_value = neg_n ? INT64_MIN : INT64_MAX;
		end else begin
			res_value = neg_n ? ('0 - acc_n) : acc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			st_q    <= ST_NONE;
			eb_q    <= '0;
			stop_q  <= '0;
		end else if (q_pop) begin
			if (q_cls.last) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				st_q    <= ST_NONE;
				eb_q    <= '0;
				stop_q  <= '0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				st_q    <= st_n;
				eb_q    <= eb_n;
				stop_q  <= stop_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (q_pop && q_cls.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_cls.last) begin
			value_q    <= res_value;
			stop_out_q <= (st_n != ST_NONE) ? stop_n : '0;
			range_q    <= (st_n == ST_OVER);
			nodig_q    <= (st_n == ST_NONE);
		end
	end

	assign res_valid   = res_valid_q;
	assign value       = value_q;
	assign stop_offset = stop_out_q;
	assign range_error = range_q;
	assign no_digits   = nodig_q;

	`TTIP_ASSERT_NOW(a_none_acc_zero, st_q == ST_NONE, acc_q == '0, "accumulator set without digits")
	`TTIP_ASSERT_NEXT(a_clear_after_last, q_pop && q_cls.last,
		phase_q == PH_SPACE && st_q == ST_NONE && !neg_q, "parse state not cleared after string")
	`TTIP_ASSERT_NOW(a_nodig_result, res_valid_q && nodig_q,
		value_q == '0 && stop_out_q == '0 && !range_q, "no-digit result not zero")

endmodule
